>>> rtl/pmft_pkg.sv
// ----------------------------------------------------------------------------
// pmft_pkg
// Shared types and constants of the page-mapped flash translation block.
// ----------------------------------------------------------------------------
package pmft_pkg;

    localparam int DEF_BLOCKS      = 16;
    localparam int DEF_BLOCK_PAGES = 8;
    localparam int DEF_LOGICAL_PAGES = 64;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam int LP_W      = 6;
    localparam int STATUS_W  = 2;
    localparam int BLK_OUT_W = 4;
    localparam int PG_OUT_W  = 3;
    localparam int CNT_OUT_W = 8;
    localparam int TOT_W     = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNMAPPED  = 2'd1,
        ST_NO_VICTIM = 2'd2,
        ST_NO_FREE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PS_FREE    = 2'd0,
        PS_VALID   = 2'd1,
        PS_INVALID = 2'd2
    } page_state_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

>>> rtl/page_mapped_flash_translation.sv
// ----------------------------------------------------------------------------
// page_mapped_flash_translation
// Page-mapped flash translation with greedy garbage collection, page state
// and map held in two synchronous memories.
//
//   Channel | Signals                                   | Transfer when
//   --------+-------------------------------------------+----------------------
//   request | in_valid/in_ready, opcode, logical_page,  | in_valid && in_ready
//           | write_data                                |
//   result  | out_valid/out_ready, status ... counters  | out_valid && out_ready
//
// A write runs a free-page search that reads the page memory one entry a
// cycle; a collection adds a full scan of the page memory, one free search
// for each relocated page and an erase write for each page of the victim
// block. After reset a clearing pass writes every entry of both memories
// before any request is taken.
// One request is in flight at a time; a stalled result holds the block.
// ----------------------------------------------------------------------------
module page_mapped_flash_translation #(
    parameter int BLOCKS        = pmft_pkg::DEF_BLOCKS,
    parameter int BLOCK_PAGES   = pmft_pkg::DEF_BLOCK_PAGES,
    parameter int LOGICAL_PAGES = pmft_pkg::DEF_LOGICAL_PAGES,
    parameter int DATA_WIDTH    = pmft_pkg::DEF_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [pmft_pkg::LP_W-1:0]      logical_page,
    input  logic [DATA_WIDTH-1:0]          write_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pmft_pkg::STATUS_W-1:0]  status,
    output logic [DATA_WIDTH-1:0]          read_data,
    output logic [pmft_pkg::BLK_OUT_W-1:0] phys_block,
    output logic [pmft_pkg::PG_OUT_W-1:0]  phys_page,
    output logic                           gc_ran,
    output logic [pmft_pkg::BLK_OUT_W-1:0] victim_block,
    output logic [pmft_pkg::CNT_OUT_W-1:0] free_total,
    output logic [pmft_pkg::CNT_OUT_W-1:0] valid_total,
    output logic [pmft_pkg::CNT_OUT_W-1:0] invalid_total,
    output logic [pmft_pkg::TOT_W-1:0]     collections_done,
    output logic [pmft_pkg::TOT_W-1:0]     erases_done,
    output logic [pmft_pkg::TOT_W-1:0]     programs_done
);

    import pmft_pkg::*;

    localparam int TP    = BLOCKS * BLOCK_PAGES;
    localparam int IW    = $clog2(TP);
    localparam int BW    = $clog2(BLOCKS);
    localparam int PW    = (BLOCK_PAGES > 1) ? $clog2(BLOCK_PAGES) : 1;
    localparam int MW    = (LOGICAL_PAGES > 1) ? $clog2(LOGICAL_PAGES) : 1;
    localparam int CW    = $clog2(TP + 1);
    localparam int NW    = $clog2(BLOCK_PAGES + 1);
    localparam int CLR_N = (TP > LOGICAL_PAGES) ? TP : LOGICAL_PAGES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int PGW   = 2 + MW + DATA_WIDTH;
    localparam int MPW   = 1 + BW + PW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MOD, S_RMAP, S_RMAPW, S_RPAGE, S_SCAN,
        S_REL_RD, S_REL_CHK, S_FREE, S_REL_WR, S_REL_INV, S_ERASE,
        S_FIN_MAP, S_FIN_MAPW, S_FIN_WR, S_FIN_INV, S_DONE
    } fsm_t;

    fsm_t                  state_reg;
    logic [CLRW-1:0]       clr_reg;
    logic                  op_reg;
    logic [LP_W-1:0]       lp_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;

    logic                  iss_reg;
    logic [IW-1:0]         sidx_reg;
    logic [BW-1:0]         sblk_reg;
    logic [PW-1:0]         spg_reg;
    logic                  dv_reg;
    logic [IW-1:0]         didx_reg;
    logic [BW-1:0]         dblk_reg;
    logic [PW-1:0]         dpg_reg;

    logic [NW-1:0]         acc_live_reg, acc_inv_reg, acc_fr_reg;
    logic [NW-1:0]         best_live_reg, best_inv_reg;
    logic                  vfound_reg;
    logic [BW-1:0]         vblk_reg;
    logic [IW-1:0]         vbase_reg;
    logic [PW-1:0]         rel_pg_reg;
    logic [MW-1:0]         mv_owner_reg;
    logic [DATA_WIDTH-1:0] mv_data_reg;

    logic [IW-1:0]         ptr_idx_reg;
    logic [BW-1:0]         ptr_blk_reg;
    logic [PW-1:0]         ptr_pg_reg;
    logic                  ptr_over_reg;
    logic                  skip_en_reg, for_final_reg;
    logic [IW-1:0]         dst_idx_reg;
    logic [BW-1:0]         dst_blk_reg;
    logic [PW-1:0]         dst_pg_reg;
    logic                  had_reg;
    logic [IW-1:0]         old_idx_reg;

    logic [CW-1:0]         free_cnt_reg, valid_cnt_reg, inv_cnt_reg;
    logic [TOT_W-1:0]      prog_cnt_reg, erase_cnt_reg, gc_cnt_reg;

    status_t               res_status_reg;
    logic [DATA_WIDTH-1:0] res_rdata_reg;
    logic [BW-1:0]         res_blk_reg;
    logic [PW-1:0]         res_pg_reg;
    logic                  res_gc_reg;
    logic [BW-1:0]         res_victim_reg;

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;
    logic [BLK_OUT_W-1:0]  phys_block_reg, victim_block_reg;
    logic [PG_OUT_W-1:0]   phys_page_reg;
    logic                  gc_ran_reg;
    logic [CNT_OUT_W-1:0]  free_total_reg, valid_total_reg, invalid_total_reg;
    logic [TOT_W-1:0]      coll_reg, erase_out_reg, prog_out_reg;

    logic                  pg_we, pg_re, mp_we, mp_re;
    logic [IW-1:0]         pg_wa, pg_ra;
    logic [PGW-1:0]        pg_wd, pg_rd;
    logic [MW-1:0]         mp_wa, mp_ra;
    logic [MPW-1:0]        mp_wd, mp_rd;

    page_state_t           cs;
    logic [NW-1:0]         live_n, inv_n, fr_n;
    logic                  blk_end, blk_take, hit;
    logic [CW-1:0]         gc_n;
    logic                  gc_due;
    logic [BW+BLK_OUT_W-1:0] res_blk_ext, res_vic_ext;
    logic [PW+PG_OUT_W-1:0]  res_pg_ext;
    logic [CW+CNT_OUT_W-1:0] free_ext, valid_ext, inv_ext;

    function automatic logic [IW-1:0] page_addr(input logic [BW-1:0] b,
                                                input logic [PW-1:0] p);
        page_addr = IW'(32'(b) * BLOCK_PAGES + 32'(p));
    endfunction

    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    pmft_ram #(.WIDTH(PGW), .DEPTH(TP)) u_page_ram (
        .clk     (clk),
        .wr_en   (pg_we),
        .wr_addr (pg_wa),
        .wr_data (pg_wd),
        .rd_en   (pg_re),
        .rd_addr (pg_ra),
        .rd_data (pg_rd)
    );

    pmft_ram #(.WIDTH(MPW), .DEPTH(LOGICAL_PAGES)) u_map_ram (
        .clk     (clk),
        .wr_en   (mp_we),
        .wr_addr (mp_wa),
        .wr_data (mp_wd),
        .rd_en   (mp_re),
        .rd_addr (mp_ra),
        .rd_data (mp_rd)
    );

    assign cs       = page_state_t'(pg_rd[PGW-1:PGW-2]);
    assign live_n   = acc_live_reg + NW'(cs == PS_VALID);
    assign inv_n    = acc_inv_reg + NW'(cs == PS_INVALID);
    assign fr_n     = acc_fr_reg + NW'(cs == PS_FREE);
    assign blk_end  = (dpg_reg == PW'(BLOCK_PAGES - 1));
    assign blk_take = blk_end && (inv_n > best_inv_reg)
                      && (CW'(live_n) <= free_cnt_reg - CW'(fr_n));
    assign hit      = (cs == PS_FREE) && !(skip_en_reg && (dblk_reg == vblk_reg));
    assign gc_n     = CW'(best_live_reg) + CW'(best_inv_reg);
    assign gc_due   = (free_cnt_reg == '0)
                      || ((free_cnt_reg <= CW'(BLOCK_PAGES)) && (inv_cnt_reg != '0));

    assign res_blk_ext = {{BLK_OUT_W{1'b0}}, res_blk_reg};
    assign res_vic_ext = {{BLK_OUT_W{1'b0}}, res_victim_reg};
    assign res_pg_ext  = {{PG_OUT_W{1'b0}}, res_pg_reg};
    assign free_ext    = {{CNT_OUT_W{1'b0}}, free_cnt_reg};
    assign valid_ext   = {{CNT_OUT_W{1'b0}}, valid_cnt_reg};
    assign inv_ext     = {{CNT_OUT_W{1'b0}}, inv_cnt_reg};

    always_comb
    begin
        pg_we = 1'b0;
        pg_wa = '0;
        pg_wd = '0;
        pg_re = 1'b0;
        pg_ra = '0;
        mp_we = 1'b0;
        mp_wa = '0;
        mp_wd = '0;
        mp_re = 1'b0;
        mp_ra = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                pg_we = (32'(clr_reg) < TP);
                pg_wa = IW'(clr_reg);
                pg_wd = {PS_FREE, {(MW + DATA_WIDTH){1'b0}}};
                mp_we = (32'(clr_reg) < LOGICAL_PAGES);
                mp_wa = MW'(clr_reg);
            end
            S_RMAP, S_FIN_MAP:
            begin
                mp_re = 1'b1;
                mp_ra = MW'(lp_reg);
            end
            S_RMAPW:
            begin
                pg_re = mp_rd[MPW-1];
                pg_ra = page_addr(mp_rd[BW+PW-1:PW], mp_rd[PW-1:0]);
            end
            S_SCAN, S_FREE:
            begin
                pg_re = iss_reg;
                pg_ra = sidx_reg;
            end
            S_REL_RD:
            begin
                pg_re = 1'b1;
                pg_ra = vbase_reg + IW'(rel_pg_reg);
            end
            S_REL_WR:
            begin
                pg_we = 1'b1;
                pg_wa = dst_idx_reg;
                pg_wd = {PS_VALID, mv_owner_reg, mv_data_reg};
                mp_we = 1'b1;
                mp_wa = mv_owner_reg;
                mp_wd = {1'b1, dst_blk_reg, dst_pg_reg};
            end
            S_REL_INV:
            begin
                pg_we = 1'b1;
                pg_wa = vbase_reg + IW'(rel_pg_reg);
                pg_wd = {PS_INVALID, {(MW + DATA_WIDTH){1'b0}}};
            end
            S_ERASE:
            begin
                pg_we = 1'b1;
                pg_wa = vbase_reg + IW'(rel_pg_reg);
                pg_wd = {PS_FREE, {(MW + DATA_WIDTH){1'b0}}};
            end
            S_FIN_WR:
            begin
                pg_we = 1'b1;
                pg_wa = dst_idx_reg;
                pg_wd = {PS_VALID, MW'(lp_reg), wdata_reg};
                mp_we = 1'b1;
                mp_wa = MW'(lp_reg);
                mp_wd = {1'b1, dst_blk_reg, dst_pg_reg};
            end
            S_FIN_INV:
            begin
                pg_we = 1'b1;
                pg_wa = old_idx_reg;
                pg_wd = {PS_INVALID, {(MW + DATA_WIDTH){1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            iss_reg        <= 1'b0;
            dv_reg         <= 1'b0;
            vfound_reg     <= 1'b0;
            free_cnt_reg   <= CW'(TP);
            valid_cnt_reg  <= '0;
            inv_cnt_reg    <= '0;
            prog_cnt_reg   <= '0;
            erase_cnt_reg  <= '0;
            gc_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            dv_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_SCAN || state_reg == S_FREE) && iss_reg)
            begin
                dv_reg   <= 1'b1;
                didx_reg <= sidx_reg;
                dblk_reg <= sblk_reg;
                dpg_reg  <= spg_reg;
                sidx_reg <= sidx_reg + 1'b1;
                if (spg_reg == PW'(BLOCK_PAGES - 1))
                begin
                    spg_reg  <= '0;
                    sblk_reg <= sblk_reg + 1'b1;
                end
                else
                begin
                    spg_reg <= spg_reg + 1'b1;
                end
                if (sidx_reg == IW'(TP - 1))
                begin
                    iss_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLRW'(CLR_N - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= opcode;
                        lp_reg         <= logical_page;
                        wdata_reg      <= write_data;
                        res_status_reg <= ST_OK;
                        res_rdata_reg  <= '0;
                        res_blk_reg    <= '0;
                        res_pg_reg     <= '0;
                        res_gc_reg     <= 1'b0;
                        res_victim_reg <= '0;
                        state_reg      <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (32'(lp_reg) >= LOGICAL_PAGES)
                    begin
                        lp_reg <= lp_reg - LP_W'(LOGICAL_PAGES);
                    end
                    else if (op_reg == OP_READ)
                    begin
                        state_reg <= S_RMAP;
                    end
                    else if (gc_due)
                    begin
                        sidx_reg      <= '0;
                        sblk_reg      <= '0;
                        spg_reg       <= '0;
                        iss_reg       <= 1'b1;
                        acc_live_reg  <= '0;
                        acc_inv_reg   <= '0;
                        acc_fr_reg    <= '0;
                        best_inv_reg  <= '0;
                        vfound_reg    <= 1'b0;
                        ptr_idx_reg   <= '0;
                        ptr_blk_reg   <= '0;
                        ptr_pg_reg    <= '0;
                        ptr_over_reg  <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_FIN_MAP;
                    end
                end
                S_RMAP:
                begin
                    state_reg <= S_RMAPW;
                end
                S_RMAPW:
                begin
                    if (!mp_rd[MPW-1])
                    begin
                        res_status_reg <= ST_UNMAPPED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        res_blk_reg <= mp_rd[BW+PW-1:PW];
                        res_pg_reg  <= mp_rd[PW-1:0];
                        state_reg   <= S_RPAGE;
                    end
                end
                S_RPAGE:
                begin
                    res_rdata_reg <= pg_rd[DATA_WIDTH-1:0];
                    state_reg     <= S_DONE;
                end
                S_SCAN:
                begin
                    if (dv_reg)
                    begin
                        if (blk_end)
                        begin
                            acc_live_reg <= '0;
                            acc_inv_reg  <= '0;
                            acc_fr_reg   <= '0;
                        end
                        else
                        begin
                            acc_live_reg <= live_n;
                            acc_inv_reg  <= inv_n;
                            acc_fr_reg   <= fr_n;
                        end
                        if (blk_take)
                        begin
                            vfound_reg    <= 1'b1;
                            vblk_reg      <= dblk_reg;
                            vbase_reg     <= didx_reg - IW'(BLOCK_PAGES - 1);
                            best_live_reg <= live_n;
                            best_inv_reg  <= inv_n;
                        end
                        if (didx_reg == IW'(TP - 1))
                        begin
                            if (vfound_reg || blk_take)
                            begin
                                rel_pg_reg <= '0;
                                state_reg  <= S_REL_RD;
                            end
                            else
                            begin
                                res_status_reg <= ST_NO_VICTIM;
                                state_reg      <= S_DONE;
                            end
                        end
                    end
                end
                S_REL_RD:
                begin
                    state_reg <= S_REL_CHK;
                end
                S_REL_CHK:
                begin
                    if (cs == PS_VALID && !ptr_over_reg)
                    begin
                        mv_owner_reg  <= pg_rd[DATA_WIDTH+MW-1:DATA_WIDTH];
                        mv_data_reg   <= pg_rd[DATA_WIDTH-1:0];
                        sidx_reg      <= ptr_idx_reg;
                        sblk_reg      <= ptr_blk_reg;
                        spg_reg       <= ptr_pg_reg;
                        iss_reg       <= 1'b1;
                        skip_en_reg   <= 1'b1;
                        for_final_reg <= 1'b0;
                        state_reg     <= S_FREE;
                    end
                    else if (cs == PS_VALID)
                    begin
                        rel_pg_reg <= '0;
                        state_reg  <= S_ERASE;
                    end
                    else if (rel_pg_reg == PW'(BLOCK_PAGES - 1))
                    begin
                        rel_pg_reg <= '0;
                        state_reg  <= S_ERASE;
                    end
                    else
                    begin
                        rel_pg_reg <= rel_pg_reg + 1'b1;
                        state_reg  <= S_REL_RD;
                    end
                end
                S_FREE:
                begin
                    if (dv_reg)
                    begin
                        if (hit)
                        begin
                            iss_reg     <= 1'b0;
                            dst_idx_reg <= didx_reg;
                            dst_blk_reg <= dblk_reg;
                            dst_pg_reg  <= dpg_reg;
                            state_reg   <= for_final_reg ? S_FIN_WR : S_REL_WR;
                        end
                        else if (didx_reg == IW'(TP - 1))
                        begin
                            if (for_final_reg)
                            begin
                                res_status_reg <= ST_NO_FREE;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                rel_pg_reg <= '0;
                                state_reg  <= S_ERASE;
                            end
                        end
                    end
                end
                S_REL_WR:
                begin
                    state_reg <= S_REL_INV;
                end
                S_REL_INV:
                begin
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                    inv_cnt_reg  <= inv_cnt_reg + 1'b1;
                    prog_cnt_reg <= sat_inc(prog_cnt_reg);
                    ptr_idx_reg  <= dst_idx_reg + 1'b1;
                    ptr_over_reg <= (dst_idx_reg == IW'(TP - 1));
                    if (dst_pg_reg == PW'(BLOCK_PAGES - 1))
                    begin
                        ptr_pg_reg  <= '0;
                        ptr_blk_reg <= dst_blk_reg + 1'b1;
                    end
                    else
                    begin
                        ptr_pg_reg  <= dst_pg_reg + 1'b1;
                        ptr_blk_reg <= dst_blk_reg;
                    end
                    if (rel_pg_reg == PW'(BLOCK_PAGES - 1))
                    begin
                        rel_pg_reg <= '0;
                        state_reg  <= S_ERASE;
                    end
                    else
                    begin
                        rel_pg_reg <= rel_pg_reg + 1'b1;
                        state_reg  <= S_REL_RD;
                    end
                end
                S_ERASE:
                begin
                    if (rel_pg_reg == PW'(BLOCK_PAGES - 1))
                    begin
                        free_cnt_reg   <= free_cnt_reg + gc_n;
                        inv_cnt_reg    <= inv_cnt_reg - gc_n;
                        erase_cnt_reg  <= sat_inc(erase_cnt_reg);
                        gc_cnt_reg     <= sat_inc(gc_cnt_reg);
                        res_gc_reg     <= 1'b1;
                        res_victim_reg <= vblk_reg;
                        state_reg      <= S_FIN_MAP;
                    end
                    else
                    begin
                        rel_pg_reg <= rel_pg_reg + 1'b1;
                    end
                end
                S_FIN_MAP:
                begin
                    state_reg <= S_FIN_MAPW;
                end
                S_FIN_MAPW:
                begin
                    had_reg       <= mp_rd[MPW-1];
                    old_idx_reg   <= page_addr(mp_rd[BW+PW-1:PW], mp_rd[PW-1:0]);
                    sidx_reg      <= '0;
                    sblk_reg      <= '0;
                    spg_reg       <= '0;
                    iss_reg       <= 1'b1;
                    skip_en_reg   <= 1'b0;
                    for_final_reg <= 1'b1;
                    state_reg     <= S_FREE;
                end
                S_FIN_WR:
                begin
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                    prog_cnt_reg <= sat_inc(prog_cnt_reg);
                    res_blk_reg  <= dst_blk_reg;
                    res_pg_reg   <= dst_pg_reg;
                    if (had_reg)
                    begin
                        inv_cnt_reg <= inv_cnt_reg + 1'b1;
                        state_reg   <= S_FIN_INV;
                    end
                    else
                    begin
                        valid_cnt_reg <= valid_cnt_reg + 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                S_FIN_INV:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg     <= 1'b1;
                        status_reg        <= res_status_reg;
                        read_data_reg     <= res_rdata_reg;
                        phys_block_reg    <= res_blk_ext[BLK_OUT_W-1:0];
                        phys_page_reg     <= res_pg_ext[PG_OUT_W-1:0];
                        gc_ran_reg        <= res_gc_reg;
                        victim_block_reg  <= res_vic_ext[BLK_OUT_W-1:0];
                        free_total_reg    <= free_ext[CNT_OUT_W-1:0];
                        valid_total_reg   <= valid_ext[CNT_OUT_W-1:0];
                        invalid_total_reg <= inv_ext[CNT_OUT_W-1:0];
                        coll_reg          <= gc_cnt_reg;
                        erase_out_reg     <= erase_cnt_reg;
                        prog_out_reg      <= prog_cnt_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign read_data        = read_data_reg;
    assign phys_block       = phys_block_reg;
    assign phys_page        = phys_page_reg;
    assign gc_ran           = gc_ran_reg;
    assign victim_block     = victim_block_reg;
    assign free_total       = free_total_reg;
    assign valid_total      = valid_total_reg;
    assign invalid_total    = invalid_total_reg;
    assign collections_done = coll_reg;
    assign erases_done      = erase_out_reg;
    assign programs_done    = prog_out_reg;

    // The three page counters always account for every physical page.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW+2)'(free_cnt_reg) + (CW+2)'(valid_cnt_reg) + (CW+2)'(inv_cnt_reg))
            == (CW+2)'(TP))
        else $error("page counters do not add up to the page total");

    a_gc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && gc_ran_reg) |-> (status_reg == ST_OK))
        else $error("collection reported on a failed request");

    a_loc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK)
            |-> (phys_block_reg == '0 && phys_page_reg == '0 && !gc_ran_reg))
        else $error("location reported on a failed request");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_MOD))
        else $error("accepted request did not start");

endmodule

>>> rtl/pmft_ram.sv
// ----------------------------------------------------------------------------
// pmft_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pmft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/ftl_checker.sv
// ----------------------------------------------------------------------------
// ftl_checker
// Watches the request and result channels of the flash translation block.
// Each accepted request updates a private model of page state, map and
// counters. The expected result is queued and compared field by field with
// every result transfer.
// ----------------------------------------------------------------------------
module ftl_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       opcode,
    input  logic [pmft_pkg::LP_W-1:0]  logical_page,
    input  logic [31:0]                write_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [1:0]                 status,
    input  logic [31:0]                read_data,
    input  logic [3:0]                 phys_block,
    input  logic [2:0]                 phys_page,
    input  logic                       gc_ran,
    input  logic [3:0]                 victim_block,
    input  logic [7:0]                 free_total,
    input  logic [7:0]                 valid_total,
    input  logic [7:0]                 invalid_total,
    input  logic [31:0]                collections_done,
    input  logic [31:0]                erases_done,
    input  logic [31:0]                programs_done,
    output int                         errors,
    output int                         pending,
    output int                         gc_seen,
    output int                         no_victim_seen
);

    import pmft_pkg::*;

    localparam int NBLK = DEF_BLOCKS;
    localparam int NPPB = DEF_BLOCK_PAGES;
    localparam int NPG  = NBLK * NPPB;
    localparam int NLP  = DEF_LOGICAL_PAGES;

    typedef struct {
        status_t     st;
        logic [31:0] rdata;
        logic [3:0]  blk;
        logic [2:0]  pg;
        logic        gc;
        logic [3:0]  victim;
        logic [7:0]  nfree;
        logic [7:0]  nvalid;
        logic [7:0]  ninvalid;
        logic [31:0] ngc;
        logic [31:0] nerase;
        logic [31:0] nprog;
    } ftl_result_t;

    page_state_t pstate [NPG];
    logic [5:0]  powner [NPG];
    logic [31:0] pdata  [NPG];
    bit          mapped [NLP];
    int          maploc [NLP];
    int          nfree, nvalid, ninvalid;
    logic [31:0] nprog, nerase, ngc, nwrite;

    ftl_result_t result_q [$];

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int find_free(int skip);
        for (int b = 0; b < NBLK; b++)
        begin
            if (b == skip)
                continue;
            for (int p = 0; p < NPPB; p++)
                if (pstate[b*NPPB+p] == PS_FREE)
                    return b*NPPB + p;
        end
        return -1;
    endfunction

    task automatic program_page(int idx, logic [5:0] owner, logic [31:0] d);
        pstate[idx] = PS_VALID;
        powner[idx] = owner;
        pdata[idx]  = d;
        nfree--;
        nvalid++;
        nprog = sat_inc(nprog);
    endtask

    task automatic invalidate_page(int idx);
        if (pstate[idx] == PS_VALID)
        begin
            pstate[idx] = PS_INVALID;
            nvalid--;
            ninvalid++;
        end
    endtask

    task automatic collect_garbage(output int victim);
        int best, live, inv, fr, dst, src;
        best = 0;
        victim = -1;
        for (int b = 0; b < NBLK; b++)
        begin
            live = 0; inv = 0; fr = 0;
            for (int p = 0; p < NPPB; p++)
                case (pstate[b*NPPB+p])
                    PS_VALID:   live++;
                    PS_INVALID: inv++;
                    default:    fr++;
                endcase
            if (inv > best && live <= nfree - fr)
            begin
                victim = b;
                best = inv;
            end
        end
        if (victim >= 0)
        begin
            for (int p = 0; p < NPPB; p++)
            begin
                src = victim*NPPB + p;
                if (pstate[src] != PS_VALID)
                    continue;
                dst = find_free(victim);
                if (dst < 0)
                    break;
                program_page(dst, powner[src], pdata[src]);
                maploc[powner[src]] = dst;
                invalidate_page(src);
            end
            for (int p = 0; p < NPPB; p++)
            begin
                src = victim*NPPB + p;
                if (pstate[src] == PS_VALID)
                begin
                    nvalid--; nfree++;
                end
                else if (pstate[src] == PS_INVALID)
                begin
                    ninvalid--; nfree++;
                end
                pstate[src] = PS_FREE;
                powner[src] = '0;
                pdata[src]  = '0;
            end
            nerase = sat_inc(nerase);
            ngc    = sat_inc(ngc);
        end
    endtask

    task automatic translate(logic op, logic [5:0] lp, logic [31:0] d,
                             output ftl_result_t r);
        int loc, v, dst, old;
        bit had;
        r = '{st: ST_OK, rdata: '0, blk: '0, pg: '0, gc: 1'b0, victim: '0,
              nfree: '0, nvalid: '0, ninvalid: '0, ngc: '0, nerase: '0, nprog: '0};
        loc = 0;
        if (op == OP_READ)
        begin
            if (!mapped[lp])
                r.st = ST_UNMAPPED;
            else
            begin
                loc = maploc[lp];
                r.rdata = pdata[loc];
            end
        end
        else
        begin
            nwrite = sat_inc(nwrite);
            if (nfree == 0 || (nfree <= NPPB && ninvalid > 0))
            begin
                collect_garbage(v);
                if (v < 0)
                    r.st = ST_NO_VICTIM;
                else
                begin
                    r.gc = 1'b1;
                    r.victim = v[3:0];
                end
            end
            if (r.st == ST_OK)
            begin
                dst = find_free(NBLK);
                if (dst < 0)
                    r.st = ST_NO_FREE;
                else
                begin
                    had = mapped[lp];
                    old = maploc[lp];
                    loc = dst;
                    program_page(dst, lp, d);
                    maploc[lp] = dst;
                    mapped[lp] = 1'b1;
                    if (had)
                        invalidate_page(old);
                end
            end
        end
        if (r.st == ST_OK)
        begin
            r.blk = 4'(loc / NPPB);
            r.pg  = 3'(loc % NPPB);
        end
        r.nfree    = nfree[7:0];
        r.nvalid   = nvalid[7:0];
        r.ninvalid = ninvalid[7:0];
        r.ngc      = ngc;
        r.nerase   = nerase;
        r.nprog    = nprog;
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        gc_seen = 0;
        no_victim_seen = 0;
        for (int i = 0; i < NPG; i++)
        begin
            pstate[i] = PS_FREE;
            powner[i] = '0;
            pdata[i]  = '0;
        end
        for (int i = 0; i < NLP; i++)
        begin
            mapped[i] = 1'b0;
            maploc[i] = 0;
        end
        nfree = NPG; nvalid = 0; ninvalid = 0;
        nprog = '0; nerase = '0; ngc = '0; nwrite = '0;
    end

    assign pending = result_q.size();

    always @(posedge clk)
    begin
        ftl_result_t r, e;
        if (rst_n && in_valid && in_ready)
        begin
            translate(opcode, logical_page, write_data, r);
            result_q.push_back(r);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                if (e.gc)
                    gc_seen++;
                if (e.st == ST_NO_VICTIM)
                    no_victim_seen++;
                check_field("status", 32'(e.st), 32'(status));
                check_field("read_data", e.rdata, read_data);
                check_field("phys_block", 32'(e.blk), 32'(phys_block));
                check_field("phys_page", 32'(e.pg), 32'(phys_page));
                check_field("gc_ran", 32'(e.gc), 32'(gc_ran));
                check_field("victim_block", 32'(e.victim), 32'(victim_block));
                check_field("free_total", 32'(e.nfree), 32'(free_total));
                check_field("valid_total", 32'(e.nvalid), 32'(valid_total));
                check_field("invalid_total", 32'(e.ninvalid), 32'(invalid_total));
                check_field("collections_done", e.ngc, collections_done);
                check_field("erases_done", e.nerase, erases_done);
                check_field("programs_done", e.nprog, programs_done);
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives read and write requests into the flash translation block with
// random gaps and result stalls, including a long result stall and a pause
// until the block drains. Directed requests come first, then random traffic
// that keeps the flash full enough for repeated garbage collection.
// ----------------------------------------------------------------------------
module tb_top;
    import pmft_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [5:0]  logical_page;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [3:0]  phys_block;
    logic [2:0]  phys_page;
    logic        gc_ran;
    logic [3:0]  victim_block;
    logic [7:0]  free_total;
    logic [7:0]  valid_total;
    logic [7:0]  invalid_total;
    logic [31:0] collections_done;
    logic [31:0] erases_done;
    logic [31:0] programs_done;

    int errors, pending, gc_seen, no_victim_seen;
    int sent, results_taken, stall_left;
    bit no_idle;

    page_mapped_flash_translation dut (.*);

    ftl_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_request(logic op, logic [5:0] lp, logic [31:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        logical_page <= lp;
        write_data   <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Result side: random stall after each transfer, one long stall.
    initial
    begin
        int k;
        out_ready = 1'b0;
        results_taken = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ready && out_valid)
            begin
                results_taken++;
                k = (results_taken == 300) ? 400 : (no_idle ? 0 : $urandom_range(0, 8));
                if (k > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left = k;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [5:0] lp;
        int hot;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        logical_page = '0;
        write_data = '0;
        sent = 0;
        no_idle = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_READ, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 6'd0, 32'h0);
        send_request(OP_WRITE, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_READ, 6'd63, 32'h0);
        send_request(OP_WRITE, 6'd0, 32'hA5A5_5A5A);
        send_request(OP_READ, 6'd0, 32'h0);
        send_request(OP_WRITE, 6'd63, 32'h5A5A_A5A5);
        send_request(OP_READ, 6'd63, 32'h0);
        send_request(OP_READ, 6'd31, 32'h0);
        send_request(OP_WRITE, 6'd42, 32'h8000_0001);
        send_request(OP_READ, 6'd42, 32'h0);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);

        for (int i = 0; i < 1340; i++)
        begin
            no_idle = (i >= 600 && i < 700);
            if (i == 900)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
            end
            hot = (i / 200) % 3;
            if (hot == 0)
                lp = 6'($urandom_range(0, 63));
            else if (hot == 1)
                lp = 6'($urandom_range(0, 7));
            else
                lp = 6'($urandom_range(40, 63));
            if ($urandom_range(0, 99) < 70)
                send_request(OP_WRITE, lp, $urandom);
            else
                send_request(OP_READ, lp, $urandom);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);

        $display("Sent %0d requests; %0d results checked.", sent, results_taken);
        $display("Collections seen: %0d, writes without a victim: %0d.",
                 gc_seen, no_victim_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
